>>> hdl/mdwo_pkg.sv
// types and constants shared by the dual wavetable oscillator voice
`default_nettype none
package mdwo_pkg;

    // field widths
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned PHASE_FRAC = 20;
    localparam int unsigned WIDX_W     = 12;
    localparam int unsigned DETUNE_W   = 25;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned VEL_W      = 7;
    localparam int unsigned VGAIN_W    = 23;
    localparam int unsigned NOTE_COUNT = 128;
    localparam int unsigned NOTE_W     = 7;
    localparam int unsigned CFG_IDX_W  = 3;

    // multiplier operand widths
    localparam int unsigned MUL_A_W = 17;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // request kinds
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_MIDI      = 2'd1;
    localparam logic [1:0] REQ_WAVE_WR   = 2'd2;
    localparam logic [1:0] REQ_STEP_WR   = 2'd3;

    // midi codes
    localparam logic [7:0] MIDI_STATUS_MASK = 8'hF0;
    localparam logic [7:0] MIDI_NOTE_ON     = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF    = 8'h80;
    localparam logic [7:0] MIDI_CTRL        = 8'hB0;
    localparam logic [7:0] MIDI_CC_MONO_ON  = 8'h7E;
    localparam logic [7:0] MIDI_CC_ALL_OFF  = 8'h7B;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OSC1_DETUNE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OSC2_DETUNE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OSC1_SHAPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OSC2_SHAPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSC1_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OSC2_GAIN      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE = 3'd7;

    // reset values of the gain registers
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'hFFFF;
    localparam logic [GAIN_W-1:0] VEL_SCALE_RESET = 16'd516;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [7:0]                 midi_status;
        logic [7:0]                 midi_data1;
        logic [7:0]                 midi_data2;
        logic [15:0]                start_delay;
        logic                       wave_select;
        logic [WIDX_W-1:0]          table_index;
        logic signed [SAMPLE_W-1:0] wave_value;
        logic [PHASE_W-1:0]         pitch_step;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_out_item;

    // operands of the shared multiplier
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    // results of the shared multiplier
    typedef struct packed {
        logic [VGAIN_W-1:0]         raw;
        logic signed [SAMPLE_W-1:0] scaled;
        logic signed [SAMPLE_W-1:0] sat;
    } t_mul_res;

endpackage
`default_nettype wire

>>> hdl/mdwo_in_if.sv
// request channel of the oscillator voice
`default_nettype none
interface mdwo_in_if;
    logic               valid;
    logic               ready;
    mdwo_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

>>> hdl/mdwo_out_if.sv
// sample channel of the oscillator voice
`default_nettype none
interface mdwo_out_if;
    logic                valid;
    logic                ready;
    mdwo_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

>>> hdl/mdwo_mul.sv
// shared signed multiplier with floor shift by 16 and 16-bit saturation
`default_nettype none
module mdwo_mul (
    input  mdwo_pkg::t_mul_op  i_op,
    output mdwo_pkg::t_mul_res o_res
);
    localparam int unsigned SHR_W = mdwo_pkg::MUL_P_W - 16;

    logic signed [mdwo_pkg::MUL_P_W-1:0]  w_prod;
    logic signed [SHR_W-1:0]              w_shr;
    logic signed [mdwo_pkg::SAMPLE_W-1:0] w_sat;

    // full product, then arithmetic shift gives the floor
    assign w_prod = i_op.a * i_op.b;
    assign w_shr  = w_prod[mdwo_pkg::MUL_P_W-1:16];

    // clamp to q1.15
    always_comb begin
        if (w_shr > $signed(SHR_W'(32767))) begin
            w_sat = 16'sh7FFF;
        end else if (w_shr < -$signed(SHR_W'(32768))) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_shr[mdwo_pkg::SAMPLE_W-1:0];
        end
    end

    // raw product, floored product and clamped product
    assign o_res = {w_prod[mdwo_pkg::VGAIN_W-1:0], w_shr[mdwo_pkg::SAMPLE_W-1:0], w_sat};
endmodule
`default_nettype wire

>>> hdl/midi_driven_dual_wavetable_oscillator.sv
// Monophonic two-oscillator wavetable voice driven by midi items.
// Loads, midi items and silent ticks complete on acceptance; a sounding tick steps through
// W1, A1, A2, B1, B2, C1 and C2 (C2 holds while the output is full) into the output register,
// and no item is taken until it is done, the shared multiplier running seven products in turn.
// Synchronous active-low reset clears control state and the registers to their
// reset values; the wave and step memories stay undefined until loaded.
`default_nettype none
module midi_driven_dual_wavetable_oscillator #(
    parameter int unsigned WAVE_DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    mdwo_in_if.sink                              i_in,
    mdwo_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [mdwo_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mdwo_pkg::DETUNE_W-1:0]        i_cfg_data
);
    localparam int unsigned AW     = $clog2(WAVE_DEPTH);
    localparam int unsigned MEM_AW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_W1   = 3'd1;
    localparam logic [2:0] S_A1   = 3'd2;
    localparam logic [2:0] S_A2   = 3'd3;
    localparam logic [2:0] S_B1   = 3'd4;
    localparam logic [2:0] S_B2   = 3'd5;
    localparam logic [2:0] S_C1   = 3'd6;
    localparam logic [2:0] S_C2   = 3'd7;

    // configuration
    logic signed [mdwo_pkg::DETUNE_W-1:0] r_detune1, r_detune2;
    logic                                 r_shape1, r_shape2;
    logic [mdwo_pkg::GAIN_W-1:0]          r_master, r_gain1, r_gain2, r_vscale;

    // voice state
    logic [2:0]                       r_state, n_state;
    logic [mdwo_pkg::PHASE_W-1:0]     r_phase1, r_phase2;
    logic [mdwo_pkg::NOTE_W-1:0]      r_held_note;
    logic [mdwo_pkg::VEL_W-1:0]       r_held_vel;
    logic [15:0]                      r_delay;
    logic                             r_sounding;

    // working registers
    logic signed [mdwo_pkg::SAMPLE_W-1:0] r_w1, r_w2, r_a1, r_a2, r_c1;
    logic [mdwo_pkg::VGAIN_W-1:0]         r_v;

    // memories
    logic [mdwo_pkg::SAMPLE_W-1:0] r_wave_mem [2*WAVE_DEPTH];
    logic [mdwo_pkg::SAMPLE_W-1:0] r_wave_q;
    logic [mdwo_pkg::PHASE_W-1:0]  r_step_mem [mdwo_pkg::NOTE_COUNT];
    logic [mdwo_pkg::PHASE_W-1:0]  r_step_q;

    // output register
    logic                r_out_valid;
    mdwo_pkg::t_out_item r_out_item;

    logic                  w_acc, w_out_free, w_tick, w_live_tick, w_out_load;
    logic [MEM_AW-1:0]     w_rd_addr, w_wr_addr;
    logic                  w_rd_en;
    logic [15:0]           w_tidx_ext, w_pidx1, w_pidx2;
    logic [7:0]            w_status;
    logic [mdwo_pkg::NOTE_W-1:0] w_note;
    logic [mdwo_pkg::VEL_W-1:0]  w_vel;
    mdwo_pkg::t_mul_op     w_op;
    mdwo_pkg::t_mul_res    w_res;

    // handshake
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_tick     = i_in.item.req_type == mdwo_pkg::REQ_TICK;
    assign i_in.ready = (r_state == S_IDLE) && (!w_tick || w_out_free);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_live_tick = w_acc && w_tick && r_sounding && (r_delay == 16'd0);

    // addresses into the wave memory
    assign w_tidx_ext = 16'(i_in.item.table_index);
    assign w_pidx1    = 16'(r_phase1[mdwo_pkg::PHASE_W-1:mdwo_pkg::PHASE_FRAC]);
    assign w_pidx2    = 16'(r_phase2[mdwo_pkg::PHASE_W-1:mdwo_pkg::PHASE_FRAC]);
    assign w_wr_addr  = {i_in.item.wave_select, w_tidx_ext[AW-1:0]};
    assign w_rd_addr  = (r_state == S_W1) ? {r_shape2, w_pidx2[AW-1:0]}
                                          : {r_shape1, w_pidx1[AW-1:0]};
    assign w_rd_en    = w_live_tick || (r_state == S_W1);

    // wave memory
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.item.req_type == mdwo_pkg::REQ_WAVE_WR) begin
            r_wave_mem[w_wr_addr] <= i_in.item.wave_value;
        end
        if (w_rd_en) begin
            r_wave_q <= r_wave_mem[w_rd_addr];
        end
    end

    // step memory
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.item.req_type == mdwo_pkg::REQ_STEP_WR &&
            i_in.item.table_index < mdwo_pkg::WIDX_W'(mdwo_pkg::NOTE_COUNT)) begin
            r_step_mem[i_in.item.table_index[mdwo_pkg::NOTE_W-1:0]] <= i_in.item.pitch_step;
        end
        if (w_live_tick) begin
            r_step_q <= r_step_mem[r_held_note];
        end
    end

    // multiplier operand select per step
    always_comb begin
        w_op = '0;
        unique case (r_state)
            S_W1: begin
                w_op.a = $signed(mdwo_pkg::MUL_A_W'(r_held_vel));
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_vscale));
            end
            S_A1: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_w1);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_gain1));
            end
            S_A2: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_w2);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_gain2));
            end
            S_B1: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_a1);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_master));
            end
            S_B2: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_a2);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_master));
            end
            S_C1: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_a1);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_v));
            end
            S_C2: begin
                w_op.a = mdwo_pkg::MUL_A_W'(r_a2);
                w_op.b = $signed(mdwo_pkg::MUL_B_W'(r_v));
            end
            default: w_op = '0;
        endcase
    end

    mdwo_mul u_mul (
        .i_op  (w_op),
        .o_res (w_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_live_tick ? S_W1 : S_IDLE;
            S_W1:    n_state = S_A1;
            S_A1:    n_state = S_A2;
            S_A2:    n_state = S_B1;
            S_B1:    n_state = S_B2;
            S_B2:    n_state = S_C1;
            S_C1:    n_state = S_C2;
            S_C2:    n_state = w_out_free ? S_IDLE : S_C2;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_out_load = (w_acc && w_tick && !w_live_tick) ||
                        (r_state == S_C2 && w_out_free);

    // midi decode
    assign w_status = i_in.item.midi_status & mdwo_pkg::MIDI_STATUS_MASK;
    assign w_note   = i_in.item.midi_data1[mdwo_pkg::NOTE_W-1:0];
    assign w_vel    = (w_status == mdwo_pkg::MIDI_NOTE_OFF) ? '0
                                      : i_in.item.midi_data2[mdwo_pkg::VEL_W-1:0];

    // control state, voice state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase1    <= '0;
            r_phase2    <= '0;
            r_held_note <= '0;
            r_held_vel  <= '0;
            r_delay     <= '0;
            r_sounding  <= 1'b0;
            r_detune1   <= '0;
            r_detune2   <= '0;
            r_shape1    <= 1'b0;
            r_shape2    <= 1'b0;
            r_master    <= mdwo_pkg::GAIN_RESET;
            r_gain1     <= mdwo_pkg::GAIN_RESET;
            r_gain2     <= mdwo_pkg::GAIN_RESET;
            r_vscale    <= mdwo_pkg::VEL_SCALE_RESET;
        end else begin
            r_state <= n_state;

            // output register occupancy
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // silent tick counts down the start delay
            if (w_acc && w_tick && r_sounding && r_delay != 16'd0) begin
                r_delay <= r_delay - 16'd1;
            end

            // note and controller messages
            if (w_acc && i_in.item.req_type == mdwo_pkg::REQ_MIDI) begin
                if (w_status == mdwo_pkg::MIDI_NOTE_ON || w_status == mdwo_pkg::MIDI_NOTE_OFF) begin
                    if (w_vel == '0 && w_note == r_held_note) begin
                        r_sounding <= 1'b0;
                    end else begin
                        r_held_note <= w_note;
                        r_held_vel  <= w_vel;
                        r_delay     <= i_in.item.start_delay;
                        r_sounding  <= 1'b1;
                        r_phase1    <= '0;
                        r_phase2    <= '0;
                    end
                end else if (w_status == mdwo_pkg::MIDI_CTRL &&
                             (i_in.item.midi_data1 == mdwo_pkg::MIDI_CC_MONO_ON ||
                              i_in.item.midi_data1 == mdwo_pkg::MIDI_CC_ALL_OFF)) begin
                    r_sounding <= 1'b0;
                end
            end

            // advance both phases once the note step is read
            if (r_state == S_W1) begin
                r_phase1 <= r_phase1 + r_step_q + mdwo_pkg::PHASE_W'(r_detune1);
                r_phase2 <= r_phase2 + r_step_q + mdwo_pkg::PHASE_W'(r_detune2);
            end

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mdwo_pkg::REG_OSC1_DETUNE:    r_detune1 <= i_cfg_data;
                    mdwo_pkg::REG_OSC2_DETUNE:    r_detune2 <= i_cfg_data;
                    mdwo_pkg::REG_OSC1_SHAPE:     r_shape1  <= i_cfg_data[0];
                    mdwo_pkg::REG_OSC2_SHAPE:     r_shape2  <= i_cfg_data[0];
                    mdwo_pkg::REG_MASTER_GAIN:    r_master  <= i_cfg_data[mdwo_pkg::GAIN_W-1:0];
                    mdwo_pkg::REG_OSC1_GAIN:      r_gain1   <= i_cfg_data[mdwo_pkg::GAIN_W-1:0];
                    mdwo_pkg::REG_OSC2_GAIN:      r_gain2   <= i_cfg_data[mdwo_pkg::GAIN_W-1:0];
                    mdwo_pkg::REG_VELOCITY_SCALE: r_vscale  <= i_cfg_data[mdwo_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers of the gain chain
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_W1: begin
                r_w1 <= r_wave_q;
                r_v  <= w_res.raw;
            end
            S_A1: begin
                r_w2 <= r_wave_q;
                r_a1 <= w_res.scaled;
            end
            S_A2: r_a2 <= w_res.scaled;
            S_B1: r_a1 <= w_res.scaled;
            S_B2: r_a2 <= w_res.scaled;
            S_C1: r_c1 <= w_res.sat;
            default: ;
        endcase

        // output item payload
        if (w_out_load) begin
            if (r_state == S_C2) begin
                r_out_item.left_sample  <= r_c1;
                r_out_item.right_sample <= w_res.sat;
            end else begin
                r_out_item <= '0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;
endmodule
`default_nettype wire
